[rtl/core/lrw_pkg.sv]
// Link recovery watchdog: shared types, codes and constants.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lrw_pkg;

  // Incoming traffic younger than this counts as proof of reachability.
  localparam logic [31:0] RX_FRESH_MS   = 32'd30000;
  // A backward clock rebase at least this large is a clock step.
  localparam logic [31:0] CLOCK_STEP_MS = 32'd60000;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REASSOC_COOLDOWN = 3'd0,
    CFG_UNREACH_REASSOC  = 3'd1,
    CFG_UNREACH_REBOOT   = 3'd2,
    CFG_HEAP_REASSOC     = 3'd3,
    CFG_HEAP_REBOOT      = 3'd4,
    CFG_MEM_LOW_THR      = 3'd5,
    CFG_MEM_CLEAR_THR    = 3'd6,
    CFG_ALLOW_REBOOT     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PROBE_NONE = 2'd0,
    PROBE_OK   = 2'd1,
    PROBE_FAIL = 2'd2
  } probe_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REASSOC = 2'd1,
    ACT_REBOOT  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REASON_NONE       = 3'd0,
    REASON_STACK_DEAD = 3'd1,
    REASON_UNREACH    = 3'd2,
    REASON_HEAP_LOW   = 3'd3,
    REASON_CLOCK_STEP = 3'd4
  } reason_e;

  typedef struct packed {
    logic [31:0] cooldown_ms;
    logic [31:0] unr_first_ms;
    logic [31:0] unr_escal_ms;
    logic [31:0] mem_first_ms;
    logic [31:0] mem_escal_ms;
    logic [31:0] mem_low_thr;
    logic [31:0] mem_clear_thr;
    logic        allow_reboot;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [31:0]        rebase_count;
    logic signed [31:0] rebase_offset_ms;
    logic               link_up;
    logic [1:0]         probe_result;
    logic [31:0]        rx_age_ms;
    logic [31:0]        free_heap;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reason_code;
    logic [31:0] recovery_total;
    logic [31:0] reboot_total;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/lrw_if.sv]
// Link recovery watchdog: valid/ready channel interfaces for samples and results.
// Depends on lrw_pkg for the payload types.
`default_nettype none

interface lrw_in_if;
  import lrw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrw_out_if;
  import lrw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/link_recovery_watchdog_top.sv]
// Link recovery watchdog top level: input register, decision engine, result register.
// Depends on lrw_pkg, lrw_if, lrw_cfg_regs and lrw_engine.
`default_nettype none

// Usage:
//  - item_i carries one health sample per transaction (time, rebase count and
//    offset, link state, probe result, inbound traffic age, free memory).
//  - result_o returns exactly one result per sample, in order: the action
//    (none, re-associate, reboot), the reason of the most recent action and
//    the wrapping recovery and reboot totals including this sample's action.
//  - Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i, one
//    register per cycle, while no sample is in flight. There is no read-back.
//  - A sample passes the input register, the engine and the result register
//    in order. Throughput: one sample per cycle while the receiver does not
//    stall. The rate is set by the watchdog state loop, which closes within
//    the engine, between the input register and the result register.
//  - Receiver stall: the result register holds its transaction; the input
//    register still advances into a freed result slot, and item_i.ready
//    drops once both registers are full.
//  - Reset (rst_ni low, asynchronous): configuration returns to its defaults,
//    all watchdog timers, flags and counters clear, both registers empty.

module link_recovery_watchdog_top #(
  parameter logic [31:0] RxFreshMs   = lrw_pkg::RX_FRESH_MS,
  parameter logic [31:0] ClockStepMs = lrw_pkg::CLOCK_STEP_MS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lrw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_wdata_i,
  lrw_in_if.sink                      item_i,
  lrw_out_if.source                   result_o
);
  import lrw_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_q, result;
  logic      out_valid_q, out_valid_d;
  logic      in_fire, advance;

  lrw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held sample moves on whenever the result slot is empty or draining.
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign in_fire      = item_i.valid && item_i.ready;

  assign in_valid_d  = in_fire || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !result_o.ready);

  lrw_engine #(
    .RxFreshMs   (RxFreshMs),
    .ClockStepMs (ClockStepMs)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= item_i.data;
    if (advance) out_q <= result;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

`default_nettype wire

[rtl/core/lrw_cfg_regs.sv]
// Link recovery watchdog: configuration register file, write-only.
// Depends on lrw_pkg (cfg_t, register index codes).
`default_nettype none

module lrw_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lrw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_wdata_i,
  output lrw_pkg::cfg_t               cfg_o
);
  import lrw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REASSOC_COOLDOWN: cfg_d.cooldown_ms   = cfg_wdata_i;
        CFG_UNREACH_REASSOC:  cfg_d.unr_first_ms  = cfg_wdata_i;
        CFG_UNREACH_REBOOT:   cfg_d.unr_escal_ms  = cfg_wdata_i;
        CFG_HEAP_REASSOC:     cfg_d.mem_first_ms  = cfg_wdata_i;
        CFG_HEAP_REBOOT:      cfg_d.mem_escal_ms  = cfg_wdata_i;
        CFG_MEM_LOW_THR:      cfg_d.mem_low_thr   = cfg_wdata_i;
        CFG_MEM_CLEAR_THR:    cfg_d.mem_clear_thr = cfg_wdata_i;
        CFG_ALLOW_REBOOT:     cfg_d.allow_reboot  = cfg_wdata_i[0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cooldown_ms   <= 32'd60000;
      cfg_q.unr_first_ms  <= 32'd60000;
      cfg_q.unr_escal_ms  <= 32'd300000;
      cfg_q.mem_first_ms  <= 32'd30000;
      cfg_q.mem_escal_ms  <= 32'd120000;
      cfg_q.mem_low_thr   <= 32'd16384;
      cfg_q.mem_clear_thr <= 32'd24576;
      cfg_q.allow_reboot  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/lrw_engine.sv]
// Link recovery watchdog: watchdog state and one-pass decision logic.
// Depends on lrw_pkg; fed from the top level's input register.
`default_nettype none

module lrw_engine #(
  parameter logic [31:0] RxFreshMs   = lrw_pkg::RX_FRESH_MS,
  parameter logic [31:0] ClockStepMs = lrw_pkg::CLOCK_STEP_MS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,   // the registered sample is consumed this cycle
  input  lrw_pkg::in_item_t  item_i,
  input  lrw_pkg::cfg_t      cfg_i,
  output lrw_pkg::out_item_t result_o
);
  import lrw_pkg::*;

  logic        started_q, started_d;
  logic [31:0] seen_rb_q, seen_rb_d;
  logic        pending_q, pending_d;
  logic [31:0] ustart_q, ustart_d;
  logic        uhandled_q, uhandled_d;
  logic [31:0] utime_q, utime_d;
  logic [31:0] hstart_q, hstart_d;
  logic        hhandled_q, hhandled_d;
  logic [31:0] htime_q, htime_d;
  logic        any_reassoc_q, any_reassoc_d;
  logic [31:0] last_reassoc_q, last_reassoc_d;
  reason_e     reason_q, reason_d;
  logic [31:0] recovery_q, recovery_d;
  logic [31:0] reboot_q, reboot_d;

  logic [31:0] now, off_u, off_mag;
  logic        step_seen, fresh, heap_low, heap_clear, cool;
  logic        c_ureboot, c_hreboot, c_step, c_ureassoc, c_hreassoc;
  action_e     act;

  assign now     = item_i.now_ms;
  assign off_u   = item_i.rebase_offset_ms;
  // Two's complement magnitude; the most negative code maps onto 2^31 as wanted.
  assign off_mag = ~off_u + 32'd1;
  assign step_seen = started_q && (item_i.rebase_count != seen_rb_q) &&
                     off_u[31] && (off_mag >= ClockStepMs);

  assign fresh      = (item_i.probe_result == PROBE_OK) ||
                      (item_i.rx_age_ms < RxFreshMs);
  assign heap_low   = item_i.free_heap < cfg_i.mem_low_thr;
  assign heap_clear = item_i.free_heap > cfg_i.mem_clear_thr;
  assign cool       = !any_reassoc_q ||
                      ((now - last_reassoc_q) >= cfg_i.cooldown_ms);

  always_comb begin
    started_d      = 1'b1;
    seen_rb_d      = item_i.rebase_count;
    pending_d      = pending_q | step_seen;
    utime_d        = utime_q;
    htime_d        = htime_q;
    any_reassoc_d  = any_reassoc_q;
    last_reassoc_d = last_reassoc_q;
    reason_d       = reason_q;
    recovery_d     = recovery_q;
    reboot_d       = reboot_q;
    act            = ACT_NONE;

    // Outage timers; a start stamp of zero means the timer is idle.
    if (!item_i.link_up) begin
      ustart_d   = '0;
      uhandled_d = 1'b0;
      hstart_d   = '0;
      hhandled_d = 1'b0;
    end else begin
      ustart_d   = ustart_q;
      uhandled_d = uhandled_q;
      if (fresh) begin
        ustart_d   = '0;
        uhandled_d = 1'b0;
      end else if (item_i.probe_result == PROBE_FAIL && ustart_q == '0) begin
        ustart_d = now;
      end
      hstart_d   = hstart_q;
      hhandled_d = hhandled_q;
      if (heap_low) begin
        if (hstart_q == '0) hstart_d = now;
      end else if (heap_clear) begin
        hstart_d   = '0;
        hhandled_d = 1'b0;
      end
    end

    c_ureboot  = uhandled_d && (ustart_d != '0) &&
                 ((now - utime_q) >= cfg_i.unr_escal_ms);
    c_hreboot  = hhandled_d && (hstart_d != '0) &&
                 ((now - htime_q) >= cfg_i.mem_escal_ms);
    c_step     = pending_d && cool;
    c_ureassoc = !uhandled_d && (ustart_d != '0) &&
                 ((now - ustart_d) >= cfg_i.unr_first_ms) && cool;
    c_hreassoc = !hhandled_d && (hstart_d != '0) &&
                 ((now - hstart_d) >= cfg_i.mem_first_ms) && cool;

    // Fixed priority; an escalation that is neither allowed nor cooled down
    // falls through to the next candidate.
    if (item_i.link_up) begin
      if (c_ureboot && cfg_i.allow_reboot) begin
        act      = ACT_REBOOT;
        reason_d = REASON_STACK_DEAD;
      end else if (c_ureboot && cool) begin
        act      = ACT_REASSOC;
        reason_d = REASON_UNREACH;
        utime_d  = now;
      end else if (c_hreboot && cfg_i.allow_reboot) begin
        act      = ACT_REBOOT;
        reason_d = REASON_HEAP_LOW;
      end else if (c_hreboot && cool) begin
        act      = ACT_REASSOC;
        reason_d = REASON_HEAP_LOW;
        htime_d  = now;
      end else if (c_step) begin
        act       = ACT_REASSOC;
        reason_d  = REASON_CLOCK_STEP;
        pending_d = 1'b0;
      end else if (c_ureassoc) begin
        act        = ACT_REASSOC;
        reason_d   = REASON_UNREACH;
        uhandled_d = 1'b1;
        utime_d    = now;
      end else if (c_hreassoc) begin
        act        = ACT_REASSOC;
        reason_d   = REASON_HEAP_LOW;
        hhandled_d = 1'b1;
        htime_d    = now;
      end
    end

    case (act)
      ACT_REASSOC: begin
        any_reassoc_d  = 1'b1;
        last_reassoc_d = now;
        recovery_d     = recovery_q + 32'd1;
      end
      ACT_REBOOT: reboot_d = reboot_q + 32'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      seen_rb_q      <= '0;
      pending_q      <= 1'b0;
      ustart_q       <= '0;
      uhandled_q     <= 1'b0;
      utime_q        <= '0;
      hstart_q       <= '0;
      hhandled_q     <= 1'b0;
      htime_q        <= '0;
      any_reassoc_q  <= 1'b0;
      last_reassoc_q <= '0;
      reason_q       <= REASON_NONE;
      recovery_q     <= '0;
      reboot_q       <= '0;
    end else if (step_i) begin
      started_q      <= started_d;
      seen_rb_q      <= seen_rb_d;
      pending_q      <= pending_d;
      ustart_q       <= ustart_d;
      uhandled_q     <= uhandled_d;
      utime_q        <= utime_d;
      hstart_q       <= hstart_d;
      hhandled_q     <= hhandled_d;
      htime_q        <= htime_d;
      any_reassoc_q  <= any_reassoc_d;
      last_reassoc_q <= last_reassoc_d;
      reason_q       <= reason_d;
      recovery_q     <= recovery_d;
      reboot_q       <= reboot_d;
    end
  end

  assign result_o.action         = act;
  assign result_o.reason_code    = reason_d;
  assign result_o.recovery_total = recovery_d;
  assign result_o.reboot_total   = reboot_d;

endmodule

`default_nettype wire

[rtl/core/lrw_checker.sv]
// Link recovery watchdog: port-level assertions, bound to the top level.
// Depends on lrw_pkg and link_recovery_watchdog_top.
`default_nettype none

module lrw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lrw_pkg::out_item_t out_data
);
  import lrw_pkg::*;

  // A stalled result transaction stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every accepted sample must be followed by a pending result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result two cycles after a sample");

  // A quiet result follows its predecessor without touching the totals.
  a_none_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.action == ACT_NONE && $past(out_valid && out_ready)
    |-> out_data.recovery_total == $past(out_data.recovery_total) &&
        out_data.reboot_total == $past(out_data.reboot_total))
    else $error("totals moved without an action");

  // A re-association bumps the recovery total by exactly one.
  a_reassoc_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.action == ACT_REASSOC && $past(out_valid && out_ready)
    |-> out_data.recovery_total == $past(out_data.recovery_total) + 32'd1 &&
        out_data.reboot_total == $past(out_data.reboot_total))
    else $error("re-association not counted");

endmodule

bind link_recovery_watchdog_top lrw_checker u_lrw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (item_i.valid),
  .in_ready  (item_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_data  (result_o.data)
);

`default_nettype wire

[dv/lrw_verdict_checker.sv]
// Scoreboard for the link recovery watchdog: predicts every result and checks it.
// Depends on lrw_pkg and lrw_if; instantiated beside the block by the testbench top.
`default_nettype none

module lrw_verdict_checker
  import lrw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  lrw_in_if                  sample_mon_i,
  lrw_out_if                 verdict_mon_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        pending_o
);

  localparam cfg_t CFG_RESET = '{
    cooldown_ms:   32'd60000,
    unr_first_ms:  32'd60000,
    unr_escal_ms:  32'd300000,
    mem_first_ms:  32'd30000,
    mem_escal_ms:  32'd120000,
    mem_low_thr:   32'd16384,
    mem_clear_thr: 32'd24576,
    allow_reboot:  1'b1
  };

  cfg_t        wd_cfg;
  logic        started, step_pending, unreach_acted, heap_acted, reassoc_seen;
  logic [31:0] seen_rebase, unreach_t0, unreach_act_t, heap_t0, heap_act_t;
  logic [31:0] last_reassoc_t, recov_cnt, reboot_cnt;
  reason_e     last_why;

  out_item_t   verdict_q [$];
  out_item_t   predicted, expected;

  function automatic logic [31:0] elapsed(input logic [31:0] now, input logic [31:0] t0);
    return now - t0;
  endfunction

  function automatic logic cooled_down(input logic [31:0] now);
    return !reassoc_seen || (elapsed(now, last_reassoc_t) >= wd_cfg.cooldown_ms);
  endfunction

  task automatic record_action(input action_e act, input reason_e why,
                               input logic [31:0] now);
    last_why = why;
    if (act == ACT_REASSOC) begin
      reassoc_seen   = 1'b1;
      last_reassoc_t = now;
      recov_cnt      = recov_cnt + 32'd1;
    end else if (act == ACT_REBOOT) begin
      reboot_cnt = reboot_cnt + 32'd1;
    end
  endtask

  task automatic step_watchdog(input in_item_t smp, output out_item_t verdict);
    logic [31:0] now;
    action_e     act;
    now = smp.now_ms;
    act = ACT_NONE;

    // first sample only latches the rebase count
    if (!started) begin
      started     = 1'b1;
      seen_rebase = smp.rebase_count;
    end else if (smp.rebase_count != seen_rebase) begin
      seen_rebase = smp.rebase_count;
      if ($signed(smp.rebase_offset_ms) <= -$signed({1'b0, CLOCK_STEP_MS}))
        step_pending = 1'b1;
    end

    if (!smp.link_up) begin
      unreach_t0    = '0;
      unreach_acted = 1'b0;
      heap_t0       = '0;
      heap_acted    = 1'b0;
    end else begin
      if (smp.probe_result == PROBE_OK || smp.rx_age_ms < RX_FRESH_MS) begin
        unreach_t0    = '0;
        unreach_acted = 1'b0;
      end else if (smp.probe_result == PROBE_FAIL && unreach_t0 == '0) begin
        unreach_t0 = now;
      end

      if (smp.free_heap < wd_cfg.mem_low_thr) begin
        if (heap_t0 == '0) heap_t0 = now;
      end else if (smp.free_heap > wd_cfg.mem_clear_thr) begin
        heap_t0    = '0;
        heap_acted = 1'b0;
      end

      // escalations, then clock step, then first-stage re-associations
      if (unreach_acted && unreach_t0 != '0 &&
          elapsed(now, unreach_act_t) >= wd_cfg.unr_escal_ms) begin
        if (wd_cfg.allow_reboot) begin
          act = ACT_REBOOT;
          record_action(act, REASON_STACK_DEAD, now);
        end else if (cooled_down(now)) begin
          unreach_act_t = now;
          act = ACT_REASSOC;
          record_action(act, REASON_UNREACH, now);
        end
      end
      if (act == ACT_NONE && heap_acted && heap_t0 != '0 &&
          elapsed(now, heap_act_t) >= wd_cfg.mem_escal_ms) begin
        if (wd_cfg.allow_reboot) begin
          act = ACT_REBOOT;
          record_action(act, REASON_HEAP_LOW, now);
        end else if (cooled_down(now)) begin
          heap_act_t = now;
          act = ACT_REASSOC;
          record_action(act, REASON_HEAP_LOW, now);
        end
      end
      if (act == ACT_NONE && step_pending && cooled_down(now)) begin
        step_pending = 1'b0;
        act = ACT_REASSOC;
        record_action(act, REASON_CLOCK_STEP, now);
      end
      if (act == ACT_NONE && !unreach_acted && unreach_t0 != '0 &&
          elapsed(now, unreach_t0) >= wd_cfg.unr_first_ms && cooled_down(now)) begin
        unreach_acted = 1'b1;
        unreach_act_t = now;
        act = ACT_REASSOC;
        record_action(act, REASON_UNREACH, now);
      end
      if (act == ACT_NONE && !heap_acted && heap_t0 != '0 &&
          elapsed(now, heap_t0) >= wd_cfg.mem_first_ms && cooled_down(now)) begin
        heap_acted = 1'b1;
        heap_act_t = now;
        act = ACT_REASSOC;
        record_action(act, REASON_HEAP_LOW, now);
      end
    end

    verdict.action         = act;
    verdict.reason_code    = last_why;
    verdict.recovery_total = recov_cnt;
    verdict.reboot_total   = reboot_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_cfg         = CFG_RESET;
      started        = 1'b0;
      step_pending   = 1'b0;
      unreach_acted  = 1'b0;
      heap_acted     = 1'b0;
      reassoc_seen   = 1'b0;
      seen_rebase    = '0;
      unreach_t0     = '0;
      unreach_act_t  = '0;
      heap_t0        = '0;
      heap_act_t     = '0;
      last_reassoc_t = '0;
      recov_cnt      = '0;
      reboot_cnt     = '0;
      last_why       = REASON_NONE;
      verdict_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
    end else begin
      // results are checked before this edge's sample is predicted
      if (verdict_mon_i.valid && verdict_mon_i.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result transaction with no prediction pending");
          mismatch_cnt_o++;
        end else begin
          expected = verdict_q.pop_front();
          if (verdict_mon_i.data.action !== expected.action) begin
            $error("action: expected %0d, got %0d",
                   expected.action, verdict_mon_i.data.action);
            mismatch_cnt_o++;
          end
          if (verdict_mon_i.data.reason_code !== expected.reason_code) begin
            $error("reason_code: expected %0d, got %0d",
                   expected.reason_code, verdict_mon_i.data.reason_code);
            mismatch_cnt_o++;
          end
          if (verdict_mon_i.data.recovery_total !== expected.recovery_total) begin
            $error("recovery_total: expected %0d, got %0d",
                   expected.recovery_total, verdict_mon_i.data.recovery_total);
            mismatch_cnt_o++;
          end
          if (verdict_mon_i.data.reboot_total !== expected.reboot_total) begin
            $error("reboot_total: expected %0d, got %0d",
                   expected.reboot_total, verdict_mon_i.data.reboot_total);
            mismatch_cnt_o++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_REASSOC_COOLDOWN: wd_cfg.cooldown_ms   = cfg_wdata_i;
          CFG_UNREACH_REASSOC:  wd_cfg.unr_first_ms  = cfg_wdata_i;
          CFG_UNREACH_REBOOT:   wd_cfg.unr_escal_ms  = cfg_wdata_i;
          CFG_HEAP_REASSOC:     wd_cfg.mem_first_ms  = cfg_wdata_i;
          CFG_HEAP_REBOOT:      wd_cfg.mem_escal_ms  = cfg_wdata_i;
          CFG_MEM_LOW_THR:      wd_cfg.mem_low_thr   = cfg_wdata_i;
          CFG_MEM_CLEAR_THR:    wd_cfg.mem_clear_thr = cfg_wdata_i;
          CFG_ALLOW_REBOOT:     wd_cfg.allow_reboot  = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (sample_mon_i.valid && sample_mon_i.ready) begin
        step_watchdog(sample_mon_i.data, predicted);
        verdict_q.push_back(predicted);
      end

      pending_o = verdict_q.size();
    end
  end

endmodule

`default_nettype wire

[dv/tb_link_recovery_watchdog_top.sv]
// Testbench top for link_recovery_watchdog_top: clock, reset, configuration
// phases, sample stimulus, result back-pressure and the final verdict.
// Depends on lrw_pkg, lrw_if, the block itself and lrw_verdict_checker.
`default_nettype none

module tb_link_recovery_watchdog_top;
  import lrw_pkg::*;

  // Generous cap: ~1250 samples, each at worst the longest sender gap plus the
  // longest receiver stall, plus two LONG_HOLD hold-offs and the drains.
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned LONG_HOLD    = 300;
  // Probe encoding 3 is not defined; the block treats it as "no probe".
  localparam logic [1:0]  PROBE_UNUSED = 2'd3;

  typedef enum int unsigned {HEAP_ZONE_LOW, HEAP_ZONE_MID, HEAP_ZONE_HIGH} heap_zone_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [31:0]        cfg_wdata;

  lrw_in_if  sample_ch ();
  lrw_out_if verdict_ch ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  // Register values of the current phase; the heap thresholds are mirrored so
  // the stimulus can land free memory below, between and above them.
  logic [31:0] cfg_plan [8];
  logic [31:0] heap_low, heap_clear;

  // Stimulus walks a wrapping clock and a rebase counter; the two episode
  // flags keep the link unreachable / memory low for runs of samples so the
  // timers actually mature instead of being cleared every other sample.
  logic [31:0] cur_now, cur_rebase;
  bit          unreach_ep, heap_ep;
  bit          hold_receiver;

  link_recovery_watchdog_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (sample_ch),
    .result_o    (verdict_ch)
  );

  lrw_verdict_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .sample_mon_i   (sample_ch),
    .verdict_mon_i  (verdict_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop if the run hangs somewhere.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Result side: short and long random stalls, a stall-free stretch in every
  // third window of the cycle counter, and a long hold-off on each request from
  // the sender so both pipeline slots fill and the sample channel backs up.
  initial begin
    int unsigned stall_left;
    int unsigned cyc;
    int unsigned r;
    stall_left = 0;
    cyc        = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_receiver) begin
        hold_receiver = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left != 0) begin
        verdict_ch.ready = 1'b0;
        stall_left--;
      end else if ((cyc / 500) % 3 == 2) begin
        verdict_ch.ready = 1'b1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 10) begin
          verdict_ch.ready = 1'b0;
          stall_left = $urandom_range(2, 0);
        end else if (r < 12) begin
          verdict_ch.ready = 1'b0;
          stall_left = $urandom_range(60, 15);
        end else begin
          verdict_ch.ready = 1'b1;
        end
      end
    end
  end

  function automatic in_item_t mk_sample(input logic [31:0] now, input logic [31:0] rb,
                                         input logic signed [31:0] off, input logic link,
                                         input logic [1:0] probe, input logic [31:0] age,
                                         input logic [31:0] heap);
    in_item_t s;
    s.now_ms           = now;
    s.rebase_count     = rb;
    s.rebase_offset_ms = off;
    s.link_up          = link;
    s.probe_result     = probe;
    s.rx_age_ms        = age;
    s.free_heap        = heap;
    return s;
  endfunction

  function automatic logic [31:0] pick_heap(input heap_zone_e zone);
    case (zone)
      HEAP_ZONE_LOW:  return (heap_low == '0) ? 32'd0 : $urandom_range(heap_low - 1, 0);
      HEAP_ZONE_MID:  return $urandom_range(heap_clear, heap_low);
      default:        return (heap_clear == 32'hFFFF_FFFF) ? heap_clear :
                             $urandom_range(32'hFFFF_FFFF, heap_clear + 1);
    endcase
  endfunction

  // Every fourth block of 60 samples goes back to back.
  function automatic int unsigned pick_gap(input int unsigned idx);
    int unsigned r;
    r = $urandom_range(99, 0);
    if ((idx / 60) % 4 == 3 || r < 70) return 0;
    if (r < 92) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(50, 20);
  endfunction

  task automatic make_random_sample(input logic [31:0] step_max, output in_item_t s);
    int unsigned r;
    logic [31:0] step;
    r = $urandom_range(99, 0);
    if (r < 8) begin
      // noise: every field fully random
      s.now_ms           = $urandom;
      s.rebase_count     = $urandom;
      s.rebase_offset_ms = $urandom;
      s.link_up          = $urandom_range(1, 0);
      s.probe_result     = $urandom_range(3, 0);
      s.rx_age_ms        = $urandom;
      s.free_heap        = $urandom;
      cur_now = s.now_ms;
    end else begin
      r = $urandom_range(99, 0);
      if (r == 0)     step = 32'hFFFF_FFFF;   // one tick backwards in wrapped time
      else if (r < 3) step = $urandom;
      else            step = $urandom_range(step_max, 0);
      cur_now  = cur_now + step;
      s.now_ms = cur_now;

      s.rebase_offset_ms = $urandom;        // ignored unless the count moves
      if ($urandom_range(99, 0) < 6) begin
        cur_rebase = ($urandom_range(9, 0) == 0) ? $urandom : cur_rebase + 32'd1;
        case ($urandom_range(3, 0))
          0: s.rebase_offset_ms = -$signed($urandom_range(400000, CLOCK_STEP_MS));
          1: s.rebase_offset_ms = -$signed($urandom_range(CLOCK_STEP_MS - 1, 0));
          2: s.rebase_offset_ms = $urandom_range(400000, 0);
          default: ;
        endcase
      end
      s.rebase_count = cur_rebase;

      if ($urandom_range(99, 0) < 5) unreach_ep = !unreach_ep;
      if ($urandom_range(99, 0) < 5) heap_ep = !heap_ep;
      s.link_up = ($urandom_range(99, 0) >= 6);

      r = $urandom_range(99, 0);
      if (unreach_ep) begin
        s.probe_result = (r < 75) ? PROBE_FAIL : (r < 88) ? PROBE_NONE : PROBE_UNUSED;
        r = $urandom_range(99, 0);
        s.rx_age_ms = (r < 95) ? $urandom_range(32'hFFFF_FFFF, RX_FRESH_MS) :
                                 $urandom_range(RX_FRESH_MS - 1, 0);
      end else begin
        s.probe_result = (r < 50) ? PROBE_OK : (r < 75) ? PROBE_NONE :
                         (r < 90) ? PROBE_FAIL : PROBE_UNUSED;
        r = $urandom_range(99, 0);
        s.rx_age_ms = (r < 70) ? $urandom_range(RX_FRESH_MS - 1, 0) :
                                 $urandom_range(32'hFFFF_FFFF, RX_FRESH_MS);
      end

      r = $urandom_range(99, 0);
      if (heap_ep) s.free_heap = pick_heap((r < 85) ? HEAP_ZONE_LOW : HEAP_ZONE_MID);
      else         s.free_heap = pick_heap((r < 80) ? HEAP_ZONE_HIGH :
                                           (r < 95) ? HEAP_ZONE_MID : HEAP_ZONE_LOW);
    end
  endtask

  // Offer one sample and return at the falling edge after its transaction;
  // valid stays high into the next sample unless a gap is inserted.
  task automatic send_sample(input in_item_t s, input int unsigned idx);
    int unsigned gap;
    sample_ch.data  = s;
    sample_ch.valid = 1'b1;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    gap = pick_gap(idx);
    if (gap != 0) begin
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has been returned.
  task automatic drain();
    sample_ch.valid = 1'b0;
    wait (pending_cnt == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_plan(input logic [31:0] cooldown, input logic [31:0] unr_reassoc,
                          input logic [31:0] unr_reboot, input logic [31:0] hp_reassoc,
                          input logic [31:0] hp_reboot, input logic [31:0] low_b,
                          input logic [31:0] clear_b, input logic [31:0] allow);
    cfg_plan[CFG_REASSOC_COOLDOWN] = cooldown;
    cfg_plan[CFG_UNREACH_REASSOC]  = unr_reassoc;
    cfg_plan[CFG_UNREACH_REBOOT]   = unr_reboot;
    cfg_plan[CFG_HEAP_REASSOC]     = hp_reassoc;
    cfg_plan[CFG_HEAP_REBOOT]      = hp_reboot;
    cfg_plan[CFG_MEM_LOW_THR]      = low_b;
    cfg_plan[CFG_MEM_CLEAR_THR]    = clear_b;
    cfg_plan[CFG_ALLOW_REBOOT]     = allow;
  endtask

  task automatic randomize_plan();
    logic [31:0] low_b;
    low_b = $urandom_range(65536, 0);
    set_plan($urandom_range(100000, 0), $urandom_range(100000, 0),
             $urandom_range(200000, 0), $urandom_range(100000, 0),
             $urandom_range(200000, 0), low_b,
             ($urandom_range(4, 0) == 0) ? $urandom_range(low_b, 0) :
                                           low_b + $urandom_range(16384, 0),
             $urandom);   // upper bits of the allow-reboot write are don't-care
  endtask

  // Registers change only with nothing in flight; all eight every phase.
  task automatic program_config();
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we    = 1'b1;
      cfg_idx   = cfg_idx_e'(i);
      cfg_wdata = cfg_plan[i];
      @(negedge clk);
    end
    cfg_we     = 1'b0;
    heap_low   = cfg_plan[CFG_MEM_LOW_THR];
    heap_clear = cfg_plan[CFG_MEM_CLEAR_THR];
  endtask

  task automatic run_phase(input int unsigned n, input logic [31:0] step_max,
                           input int unsigned hold_at, input int unsigned pause_at);
    in_item_t s;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == hold_at) hold_receiver = 1'b1;
      if (i == pause_at) drain();
      make_random_sample(step_max, s);
      send_sample(s, i);
    end
  endtask

  initial begin
    sample_ch.valid  = 1'b0;
    sample_ch.data   = '0;
    verdict_ch.ready = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_REASSOC_COOLDOWN;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    hold_receiver    = 1'b0;
    unreach_ep       = 1'b0;
    heap_ep          = 1'b0;
    cur_now          = '0;
    cur_rebase       = '0;
    heap_low         = 32'd16384;
    heap_clear       = 32'd24576;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Phase 0: reset values written back explicitly, then directed samples.
    set_plan(32'd60000, 32'd60000, 32'd300000, 32'd30000, 32'd120000,
             32'd16384, 32'd24576, 32'd1);
    program_config();

    // first sample at time zero: rebase count only latched, timers stay idle
    send_sample(mk_sample(32'd0, 32'd5, 32'sh8000_0000, 1'b1, PROBE_FAIL,
                          32'hFFFF_FFFF, 32'd0), 0);
    // unreachable and low-memory timers start
    send_sample(mk_sample(32'd10000, 32'd5, 32'sd0, 1'b1, PROBE_FAIL, 32'd40000, 32'd100), 1);
    // backward step of exactly the threshold wins over the mature heap timer
    send_sample(mk_sample(32'd45000, 32'd6, -32'sd60000, 1'b1, PROBE_FAIL,
                          32'd40000, 32'd100), 2);
    // unreachable timer mature but cooldown still running
    send_sample(mk_sample(32'd80000, 32'd6, 32'sd0, 1'b1, PROBE_FAIL, 32'd40000, 32'd100), 3);
    // cooldown over: unreachable first, then low memory
    send_sample(mk_sample(32'd105000, 32'd6, 32'sd0, 1'b1, PROBE_FAIL, 32'd40000, 32'd100), 4);
    send_sample(mk_sample(32'd170000, 32'd6, 32'sd0, 1'b1, PROBE_FAIL, 32'd40000, 32'd100), 5);
    // escalation after the unreachable action: reboot
    send_sample(mk_sample(32'd410000, 32'd6, 32'sd0, 1'b1, PROBE_FAIL, 32'd40000, 32'd100), 6);
    // link down with the most negative offset: step still noted, timers cleared
    send_sample(mk_sample(32'd420000, 32'd7, 32'sh8000_0000, 1'b0, PROBE_FAIL,
                          32'd40000, 32'd100), 7);
    // undefined probe code, fresh traffic, maximum memory; pending step fires
    send_sample(mk_sample(32'd430000, 32'd8, 32'sh7FFF_FFFF, 1'b1, PROBE_UNUSED,
                          32'd0, 32'hFFFF_FFFF), 8);
    // step one short of the threshold; memory in the hysteresis band
    send_sample(mk_sample(32'd440000, 32'd9, -32'sd59999, 1'b1, PROBE_OK,
                          32'hFFFF_FFFF, 32'd20000), 9);
    // jump to just below the wrap point, then across it
    send_sample(mk_sample(32'hFFFF_FFF0, 32'd9, 32'sd0, 1'b1, PROBE_FAIL,
                          32'hFFFF_FFFF, 32'd0), 10);
    send_sample(mk_sample(32'h0000_F000, 32'd9, 32'sd0, 1'b1, PROBE_FAIL,
                          32'hFFFF_FFFF, 32'd0), 11);
    send_sample(mk_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, PROBE_NONE,
                          32'd29999, 32'd16383), 12);
    cur_now    = 32'hFFFF_FFFF;
    cur_rebase = 32'hFFFF_FFFF;
    run_phase(PHASE_ITEMS, 32'd20000, 50, PHASE_ITEMS);

    // Phase 1: tiny timer thresholds, high memory thresholds, zero cooldown, no reboots (fallback path).
    set_plan(32'd0, 32'd1000, 32'd5000, 32'd0, 32'd3000,
             32'h8000_0000, 32'h9000_0000, 32'd0);
    program_config();
    run_phase(PHASE_ITEMS, 32'd1500, PHASE_ITEMS, 120);

    // Phase 2: every threshold at its maximum; time moves in huge steps.
    set_plan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    program_config();
    run_phase(PHASE_ITEMS, 32'h4000_0000, PHASE_ITEMS, PHASE_ITEMS);

    // Phase 3: random moderate settings.
    randomize_plan();
    program_config();
    run_phase(PHASE_ITEMS, 32'd10000, 100, PHASE_ITEMS);

    // Phase 4: memory can never be low; any nonzero free memory clears.
    set_plan(32'd5000, 32'd20000, 32'd30000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    program_config();
    run_phase(PHASE_ITEMS, 32'd5000, PHASE_ITEMS, PHASE_ITEMS);

    // Phase 5: random settings again.
    randomize_plan();
    program_config();
    run_phase(PHASE_ITEMS, 32'd10000, PHASE_ITEMS, PHASE_ITEMS);

    sample_ch.valid = 1'b0;
    wait (pending_cnt == 0);
    repeat (8) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
